@@ rtl/slt_pkg.sv @@
// Shared types and constants for the sorted list table.
package slt_pkg;

  // Table geometry
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths of the words on the ports
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  // Common width for comparing a requested index against the fill count
  localparam int IXC_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT,
    ST_RESP
  } state_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index;
  } req_word_t;

  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  value_out;
    logic [COUNT_W-1:0]        count;
  } rsp_word_t;

  // One write port and one read port into the entry memory
  typedef struct packed {
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [DATA_W-1:0]         wdata;
    logic [ADDR_W-1:0]         raddr;
  } mem_req_t;

endpackage

@@ rtl/sorted_list_table.sv @@
// Top level of the sorted list table: sequencer, entry memory and response register.
//
// Holds up to DEPTH signed 32-bit values in ascending order in one RAM with one
// write and one registered read port. One command is worked at a time, and each
// gives one response word carrying the fill count after the command. Insert
// walks down from the last entry, moving each entry that is not less than the
// new value up one place. Remove walks the whole table once and closes the gap
// as it goes; find stops at the first match; read at index reads one entry. An
// insert into a full table, a remove or find on an empty table and an
// out-of-range read answer without a walk, and an insert into an empty table
// writes the first entry directly. The walk length is set by the single RAM
// read port, one entry per cycle. A response word may wait in the output
// register while the next command is taken. Memory contents need no clearing
// after reset.
module sorted_list_table (
  input  logic                clk,
  input  logic                rst,
  input  slt_pkg::req_word_t  req,
  input  logic                req_valid,
  output logic                req_ready,
  output slt_pkg::rsp_word_t  rsp,
  output logic                rsp_valid,
  input  logic                rsp_ready
);

  import slt_pkg::*;

  mem_req_t           mem;
  logic [DATA_W-1:0]  rdata;
  rsp_word_t          res;
  logic               res_valid;
  logic               res_free;

  assign res_free = !rsp_valid || rsp_ready;

  slt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .mem       (mem),
    .rdata     (rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_free  (res_free)
  );

  slt_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule

@@ rtl/slt_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module slt_ram #(
  parameter int DEPTH_P = 64,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH_P-1:0]         wdata,
  input  logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/slt_seq.sv @@
// Command sequencer: walks the entry memory one address per cycle and shifts entries.
module slt_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  slt_pkg::req_word_t         req,
  input  logic                       req_valid,
  output logic                       req_ready,
  output slt_pkg::mem_req_t          mem,
  input  logic [slt_pkg::DATA_W-1:0] rdata,
  output slt_pkg::rsp_word_t         res,
  output logic                       res_valid,
  input  logic                       res_free
);

  import slt_pkg::*;

  // Control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               more;     // reads still to issue
  logic               dvalid;   // read data arrives this cycle
  logic               found;    // remove: match already seen

  // Held command and scan pointers
  cmd_t                      cmd;
  logic signed [DATA_W-1:0]  val;
  logic [ADDR_W-1:0]         iptr;
  logic [ADDR_W-1:0]         daddr;
  logic                      res_ok;
  logic [DATA_W-1:0]         res_val;

  // Decisions
  logic [ADDR_W-1:0]  last;
  logic               addr_end;
  logic               hit;
  logic               not_less;
  logic               at_last;
  logic               idx_ok;
  logic               accept;
  state_t             start_state;
  logic [ADDR_W-1:0]  start_ptr;
  logic               scan_done;
  logic               scan_ok;
  logic [DATA_W-1:0]  scan_val;
  logic               to_put;
  logic               cnt_up;
  logic               cnt_dn;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DATA_W-1:0]  wr_data;

  assign last     = ADDR_W'(count - CNT_W'(1));
  assign hit      = (rdata == $unsigned(val));
  assign not_less = ($signed(rdata) >= val);
  assign at_last  = (daddr == last);
  assign idx_ok   = (IXC_W'(req.index) < IXC_W'(count));
  assign accept   = req_valid && req_ready;

  // Last read of the walk: insert walks down, remove and find walk up, read issues a single read
  always_comb begin
    case (cmd)
      CMD_INSERT: addr_end = (iptr == '0);
      CMD_READ:   addr_end = 1'b1;
      default:    addr_end = (iptr == last);
    endcase
  end

  // Where a new command starts
  always_comb begin
    start_state = ST_SCAN;
    start_ptr   = '0;
    unique case (req.command)
      CMD_INSERT: begin
        start_ptr = last;
        if (count == CNT_W'(DEPTH)) begin
          start_state = ST_RESP;
        end else if (count == '0) begin
          start_state = ST_PUT;
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        if (count == '0) begin
          start_state = ST_RESP;
        end
      end
      CMD_READ: begin
        start_ptr = ADDR_W'(req.index);
        if (!idx_ok) begin
          start_state = ST_RESP;
        end
      end
    endcase
  end

  // Handle one word of read data during the walk, or the single write in ST_PUT
  always_comb begin
    scan_done = 1'b0;
    scan_ok   = 1'b0;
    scan_val  = '0;
    to_put    = 1'b0;
    cnt_up    = 1'b0;
    cnt_dn    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = daddr + ADDR_W'(1);
    wr_data   = rdata;
    if (state == ST_SCAN && dvalid) begin
      case (cmd)
        CMD_INSERT: begin
          // entries not less than the value move up one place
          wr_en = 1'b1;
          if (not_less) begin
            to_put = (daddr == '0);
          end else begin
            wr_data   = $unsigned(val);
            scan_done = 1'b1;
            scan_ok   = 1'b1;
            cnt_up    = 1'b1;
          end
        end
        CMD_REMOVE: begin
          // entries after the match move down one place
          if (found) begin
            wr_en   = 1'b1;
            wr_addr = daddr - ADDR_W'(1);
          end
          if (at_last) begin
            scan_done = 1'b1;
            scan_ok   = found || hit;
            cnt_dn    = found || hit;
          end
        end
        CMD_FIND: begin
          if (hit) begin
            scan_done = 1'b1;
            scan_ok   = 1'b1;
            scan_val  = rdata;
          end else if (at_last) begin
            scan_done = 1'b1;
          end
        end
        CMD_READ: begin
          scan_done = 1'b1;
          scan_ok   = 1'b1;
          scan_val  = rdata;
        end
      endcase
    end else if (state == ST_PUT) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = $unsigned(val);
      cnt_up  = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = start_state;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_RESP;
        end else if (to_put) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready     = (state == ST_IDLE);
    res_valid     = (state == ST_RESP) && res_free;
    res.ok        = res_ok;
    res.value_out = $signed(res_val);
    res.count     = COUNT_W'(count);
    mem.we        = wr_en;
    mem.waddr     = wr_addr;
    mem.wdata     = wr_data;
    mem.raddr     = iptr;
  end

  always_comb begin
    count_next = count;
    if (cnt_up) begin
      count_next = count + CNT_W'(1);
    end else if (cnt_dn) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      more   <= 1'b0;
      dvalid <= 1'b0;
      found  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) begin
        more   <= (start_state == ST_SCAN);
        dvalid <= 1'b0;
        found  <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (scan_done || to_put) begin
          more   <= 1'b0;
          dvalid <= 1'b0;
        end else begin
          dvalid <= more;
          if (more) begin
            more <= !addr_end;
          end
          if (dvalid && cmd == CMD_REMOVE && hit) begin
            found <= 1'b1;
          end
        end
      end
    end
  end

  // Command and pointer registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= req.command;
      val     <= req.value;
      iptr    <= start_ptr;
      res_ok  <= 1'b0;
      res_val <= '0;
    end else if (state == ST_SCAN) begin
      daddr <= iptr;
      if (more) begin
        iptr <= (cmd == CMD_INSERT) ? iptr - ADDR_W'(1) : iptr + ADDR_W'(1);
      end
      if (scan_done) begin
        res_ok  <= scan_ok;
        res_val <= scan_val;
      end
    end else if (state == ST_PUT) begin
      res_ok  <= 1'b1;
      res_val <= '0;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for sorted_list_table: queued command driver, predictor, response monitor.
module tb_top;
  import slt_pkg::*;

  localparam int CMD_TOTAL   = 1575;
  localparam int STALL_LIMIT = 2000;

  logic       clk;
  logic       rst = 1'b1;
  req_word_t  req = '0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  rsp_word_t  rsp;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;

  sorted_list_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  // Commands waiting to be driven, responses awaited in order
  req_word_t cmd_queue[$];
  rsp_word_t awaited_rsp[$];

  // Predicted table contents
  logic signed [DATA_W-1:0] tbl_vals [DEPTH];
  logic [COUNT_W-1:0]       tbl_count = '0;

  // Rough picture of the table while commands are generated, used to aim hits
  logic signed [DATA_W-1:0] gen_values[$];

  int err_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the predicted table and give the response word
  function automatic rsp_word_t table_apply(req_word_t w);
    rsp_word_t r;
    int p;
    int i;
    r = '0;
    case (w.command)
      CMD_INSERT: begin
        if (tbl_count < DEPTH) begin
          p = 0;
          while (p < tbl_count && tbl_vals[p] < w.value) p++;
          for (i = tbl_count; i > p; i--) tbl_vals[i] = tbl_vals[i-1];
          tbl_vals[p] = w.value;
          tbl_count++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        p = 0;
        while (p < tbl_count && tbl_vals[p] != w.value) p++;
        if (p < tbl_count) begin
          for (i = p; i + 1 < tbl_count; i++) tbl_vals[i] = tbl_vals[i+1];
          tbl_count--;
          r.ok = 1'b1;
        end
      end
      CMD_FIND: begin
        for (i = 0; i < tbl_count; i++) begin
          if (!r.ok && tbl_vals[i] == w.value) begin
            r.ok = 1'b1;
            r.value_out = tbl_vals[i];
          end
        end
      end
      CMD_READ: begin
        if (w.index < tbl_count) begin
          r.ok = 1'b1;
          r.value_out = tbl_vals[w.index];
        end
      end
      default: ;
    endcase
    r.count = tbl_count;
    return r;
  endfunction

  task automatic log_error(string msg);
    if (err_count < 10) $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Queue one command and keep the generation-time picture in step
  task automatic add_item(cmd_t c, logic signed [DATA_W-1:0] v, logic [INDEX_W-1:0] ix);
    req_word_t w;
    int i;
    int hit;
    w.command = c;
    w.value   = v;
    w.index   = ix;
    cmd_queue.push_back(w);
    if (c == CMD_INSERT && gen_values.size() < DEPTH) begin
      gen_values.push_back(v);
    end else if (c == CMD_REMOVE) begin
      hit = -1;
      for (i = 0; i < gen_values.size(); i++)
        if (hit < 0 && gen_values[i] == v) hit = i;
      if (hit >= 0) gen_values.delete(hit);
    end
  endtask

  // Half small values so duplicates occur, some extremes, some full range
  function automatic logic signed [DATA_W-1:0] fresh_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return int'($urandom_range(0, 31)) - 16;
    if (sel < 7) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7fff_ffff;
        3: return 32'sh7fff_fffe;
        4: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  // Value likely present in the table
  function automatic logic signed [DATA_W-1:0] known_value();
    if (gen_values.size() > 0 && $urandom_range(0, 9) < 7)
      return gen_values[$urandom_range(0, gen_values.size() - 1)];
    return fresh_value();
  endfunction

  task automatic add_random(int ins_pct);
    int r;
    logic [INDEX_W-1:0] ix;
    r  = $urandom_range(0, 99);
    ix = INDEX_W'($urandom_range(0, 63));
    if (r < ins_pct) begin
      add_item(CMD_INSERT, fresh_value(), ix);
    end else begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        add_item(CMD_REMOVE, known_value(), ix);
      end else if (r < 7) begin
        add_item(CMD_FIND, known_value(), ix);
      end else begin
        if (gen_values.size() > 0 && $urandom_range(0, 9) < 6)
          ix = INDEX_W'($urandom_range(0, gen_values.size() - 1));
        add_item(CMD_READ, $urandom(), ix);
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    // Empty table: reads, finds and removes all miss
    add_item(CMD_READ,   32'sd0, 6'd0);
    add_item(CMD_FIND,   32'sd5, 6'd0);
    add_item(CMD_REMOVE, 32'sd5, 6'h3f);
    // Extremes and a duplicate
    add_item(CMD_INSERT, 32'sd0, 6'd0);
    add_item(CMD_INSERT, 32'sh7fff_ffff, 6'h3f);
    add_item(CMD_INSERT, 32'sh8000_0000, 6'd0);
    add_item(CMD_INSERT, -32'sd1, 6'd0);
    add_item(CMD_INSERT, 32'sd0, 6'd0);
    add_item(CMD_INSERT, 32'sd1, 6'd0);
    // Find hits and a miss
    add_item(CMD_FIND,   32'sh8000_0000, 6'd0);
    add_item(CMD_FIND,   32'sh7fff_ffff, 6'd0);
    add_item(CMD_FIND,   32'sd2, 6'd0);
    // Reads: first, last, at the count, top of index range
    add_item(CMD_READ,   32'sd0, 6'd0);
    add_item(CMD_READ,   32'sd0, 6'd5);
    add_item(CMD_READ,   -32'sd1, 6'd6);
    add_item(CMD_READ,   32'sd0, 6'h3f);
    // Duplicates go one at a time, then miss
    add_item(CMD_REMOVE, 32'sd0, 6'd0);
    add_item(CMD_REMOVE, 32'sd0, 6'd0);
    add_item(CMD_REMOVE, 32'sd0, 6'd0);
    add_item(CMD_REMOVE, 32'sh7fff_ffff, 6'd0);
    add_item(CMD_REMOVE, 32'sh8000_0000, 6'd0);
    add_item(CMD_INSERT, 32'sh5555_5555, 6'h2a);
    add_item(CMD_INSERT, 32'shaaaa_aaaa, 6'h15);
    add_item(CMD_READ,   32'sd0, 6'd2);

    // Fill past full first, then segments that grow, churn or drain the table
    repeat (100) add_random(90);
    while (cmd_queue.size() < CMD_TOTAL) begin
      case ($urandom_range(0, 2))
        0: repeat ($urandom_range(40, 160)) add_random(80);
        1: repeat ($urandom_range(20, 120)) add_random(40);
        default: repeat ($urandom_range(20, 120)) add_random(10);
      endcase
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || req_valid || awaited_rsp.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (err_count == 0 && awaited_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Command driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (req_valid && req_ready) awaited_rsp.push_back(table_apply(req));
      if (!req_valid || req_ready) begin
        if (gap_left > 0 || cmd_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_valid <= 1'b0;
        end else begin
          req <= cmd_queue.pop_front();
          req_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Response monitor and receiver stall pattern
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          log_error($sformatf("response word with none outstanding: ok=%0b value=%0d count=%0d",
                              rsp.ok, rsp.value_out, rsp.count));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.ok !== want.ok || rsp.value_out !== want.value_out ||
              rsp.count !== want.count)
            log_error($sformatf("expected ok=%0b value=%0d count=%0d, got ok=%0b value=%0d count=%0d",
                                want.ok, want.value_out, want.count,
                                rsp.ok, rsp.value_out, rsp.count));
        end
      end
      // Stall modes: always ready, coin flip, one in four, mostly ready
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        2: rsp_ready <= (stall_phase % 4 == 0);
        default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog on cycles with no handshake while work is outstanding
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (cmd_queue.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
